### hw/rtl/lcrs_pkg.sv
// ----------------------------------------------------------------------------
// lcrs_pkg
// shared types, sizes and codes of the lock contention range statistics block
// ----------------------------------------------------------------------------
package lcrs_pkg;

  localparam int RANGE_ENTRIES = 256;
  localparam int CPU_SLOTS     = 16;
  localparam int TASK_SLOTS    = 64;

  localparam int RIDX_W = $clog2(RANGE_ENTRIES);
  localparam int RCNT_W = 9;
  localparam int CPU_W  = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
  localparam int TASK_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [5:0] FLAG_SPIN  = 6'd1;
  localparam logic [5:0] FLAG_READ  = 6'd2;
  localparam logic [5:0] FLAG_WRITE = 6'd4;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_NO_RANGE = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_NO_MATCH = 3'd3;
  localparam logic [2:0] ST_NEGATIVE = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  range_index;
    logic [63:0] range_start;
    logic [63:0] range_length;
    logic [3:0]  range_kind;
    logic [63:0] lock_address;
    logic [5:0]  lock_flags;
    logic [63:0] timestamp_ns;
    logic [3:0]  cpu_index;
    logic [5:0]  task_slot;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  matched_range;
    logic [63:0] dur_sum;
    logic [31:0] event_count;
    logic [63:0] dur_min;
    logic [63:0] dur_max;
    logic [5:0]  first_flags;
  } out_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              idx_ok;
    logic              spin;
    logic [RIDX_W-1:0] idx;
    logic [63:0]       start;
    logic [63:0]       length;
    logic [3:0]        kind;
    logic [63:0]       addr;
    logic [5:0]        flags;
    logic [63:0]       now;
    logic [CPU_W-1:0]  cpu;
    logic [TASK_W-1:0] task_id;
  } qitem_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
    logic [3:0]  kind;
  } tbl_t;

  typedef struct packed {
    logic [63:0] total;
    logic [31:0] count;
    logic [63:0] tmin;
    logic [63:0] tmax;
    logic [5:0]  flags;
  } stat_t;

  typedef struct packed {
    logic [63:0]       lock;
    logic [63:0]       t0;
    logic [5:0]        flags;
    logic [RIDX_W-1:0] rng;
  } pend_t;

endpackage

### hw/rtl/lock_contention_range_stats.sv
// ----------------------------------------------------------------------------
// lock_contention_range_stats
// per-range lock contention statistics over a sorted table of address ranges
// ----------------------------------------------------------------------------
// in_valid/in_ready/in_data carry command beats: load range, contention
// begin, contention end, read statistics. out_valid/out_ready/out_data carry
// exactly one result beat per command, in order.
// cfg_we/cfg_wdata set the number of loaded ranges the search covers.
// Once dequeued: load writes the table; read fetches statistics, then answers;
// end fetches pending slots, then answers or updates statistics; begin makes up
// to 9 table probes at 256 ranges, one at a time through the single read port.
// A two-beat queue sits between the input side and the sequencer, so input
// beats are still taken while a result waits in the output register.
// When the receiver stalls, the sequencer holds before taking the next
// command and the queue fills, then in_ready drops.
// Reset clears the range count, statistics and pending slots through valid
// bits at once; there is no clearing pass. Table entries hold nothing
// defined until loaded.
// ----------------------------------------------------------------------------
module lock_contention_range_stats (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [8:0]     cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  lcrs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lcrs_pkg::out_t out_data
);

  logic q_full, q_push, q_pop, q_valid;
  lcrs_pkg::qitem_t push_item, pop_item;

  lcrs_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  lcrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  lcrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/lcrs_front.sv
// ----------------------------------------------------------------------------
// lcrs_front
// accepts input beats, classifies them and pushes them into the work queue
// ----------------------------------------------------------------------------
module lcrs_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  lcrs_pkg::in_t    in_data,
  input  logic             q_full,
  output logic             q_push,
  output lcrs_pkg::qitem_t q_item
);

  logic [5:0] f;

  assign f        = in_data.lock_flags;
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.op      = in_data.command;
    q_item.idx_ok  = {1'b0, in_data.range_index} < 9'(lcrs_pkg::RANGE_ENTRIES);
    q_item.spin    = (f == lcrs_pkg::FLAG_SPIN) ||
                     (f == (lcrs_pkg::FLAG_SPIN | lcrs_pkg::FLAG_READ)) ||
                     (f == (lcrs_pkg::FLAG_SPIN | lcrs_pkg::FLAG_WRITE));
    q_item.idx     = in_data.range_index[lcrs_pkg::RIDX_W-1:0];
    q_item.start   = in_data.range_start;
    q_item.length  = in_data.range_length;
    q_item.kind    = in_data.range_kind;
    q_item.addr    = in_data.lock_address;
    q_item.flags   = f;
    q_item.now     = in_data.timestamp_ns;
    q_item.cpu     = in_data.cpu_index[lcrs_pkg::CPU_W-1:0];
    q_item.task_id = in_data.task_slot[lcrs_pkg::TASK_W-1:0];
  end

endmodule

### hw/rtl/lcrs_queue.sv
// ----------------------------------------------------------------------------
// lcrs_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module lcrs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcrs_pkg::qitem_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output lcrs_pkg::qitem_t pop_item
);

  lcrs_pkg::qitem_t mem_r [lcrs_pkg::QDEPTH];
  logic [lcrs_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [lcrs_pkg::QCNT_W-1:0] cnt_r;

  assign full      = cnt_r == lcrs_pkg::QCNT_W'(lcrs_pkg::QDEPTH);
  assign pop_valid = cnt_r != '0;
  assign pop_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == lcrs_pkg::QPTR_W'(lcrs_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop && pop_valid) begin
        rp_r <= (rp_r == lcrs_pkg::QPTR_W'(lcrs_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + lcrs_pkg::QCNT_W'(push) - lcrs_pkg::QCNT_W'(pop && pop_valid);
    end
  end

endmodule

### hw/rtl/lcrs_back.sv
// ----------------------------------------------------------------------------
// lcrs_back
// sequencer: range search, pending slots, statistics update and result register
// ----------------------------------------------------------------------------
module lcrs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [8:0]       cfg_wdata,
  input  logic             q_valid,
  input  lcrs_pkg::qitem_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output lcrs_pkg::out_t   out_data
);

  localparam int RI = lcrs_pkg::RIDX_W;
  localparam int RC = lcrs_pkg::RCNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0] state_r, state_nxt;
  lcrs_pkg::qitem_t item_r, item_nxt;
  logic [RC-1:0] lo_r, lo_nxt, hx_r, hx_nxt, rcnt_r;
  logic [RI-1:0] m_r, m_nxt, r_r, r_nxt;
  logic [63:0] dur_r, dur_nxt;
  logic [5:0] pf_r, pf_nxt;
  logic out_valid_r;
  lcrs_pkg::out_t out_r, res;
  logic res_load;

  lcrs_pkg::tbl_t  tbl_mem [lcrs_pkg::RANGE_ENTRIES];
  lcrs_pkg::stat_t st_mem  [lcrs_pkg::RANGE_ENTRIES];
  lcrs_pkg::pend_t sp_mem  [lcrs_pkg::CPU_SLOTS];
  lcrs_pkg::pend_t tk_mem  [lcrs_pkg::TASK_SLOTS];
  lcrs_pkg::tbl_t  tbl_rd_r;
  lcrs_pkg::stat_t st_rd_r, st_new;
  lcrs_pkg::pend_t sp_rd_r, tk_rd_r, pend_w, ent;
  logic [lcrs_pkg::RANGE_ENTRIES-1:0] st_v_r;
  logic [lcrs_pkg::CPU_SLOTS-1:0]     sp_v_r;
  logic [lcrs_pkg::TASK_SLOTS-1:0]    tk_v_r;

  logic tbl_we, tbl_re, st_we, st_re, pd_re, sp_we, tk_we, sp_clr, tk_clr;
  logic [RI-1:0] tbl_ra, st_ra;
  logic [RC-1:0] n_eff, lo_n, hx_n;
  logic [RC:0] msum;
  logic [63:0] s_end, sp_lock, tk_lock, lock_sel, dur_c;
  logic hit, busy, use_spin;

  assign q_pop     = (state_r == S_IDLE) && q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // memories
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[q_item.idx] <= '{start: q_item.start, length: q_item.length, kind: q_item.kind};
    end
    if (tbl_re) begin
      tbl_rd_r <= tbl_mem[tbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[r_r] <= st_new;
    end
    if (st_re) begin
      st_rd_r <= st_mem[st_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      sp_mem[item_r.cpu] <= pend_w;
    end
    if (pd_re) begin
      sp_rd_r <= sp_mem[q_item.cpu];
    end
  end

  always_ff @(posedge clk) begin
    if (tk_we) begin
      tk_mem[item_r.task_id] <= pend_w;
    end
    if (pd_re) begin
      tk_rd_r <= tk_mem[q_item.task_id];
    end
  end

  always_comb begin
    n_eff    = (rcnt_r > RC'(lcrs_pkg::RANGE_ENTRIES)) ? RC'(lcrs_pkg::RANGE_ENTRIES) : rcnt_r;
    s_end    = tbl_rd_r.start + tbl_rd_r.length;
    hit      = (item_r.addr >= tbl_rd_r.start) && (item_r.addr <= s_end);
    sp_lock  = sp_v_r[item_r.cpu] ? sp_rd_r.lock : 64'd0;
    tk_lock  = tk_v_r[item_r.task_id] ? tk_rd_r.lock : 64'd0;
    use_spin = sp_lock != 64'd0;
    ent      = use_spin ? sp_rd_r : tk_rd_r;
    lock_sel = use_spin ? sp_lock : tk_lock;
    dur_c    = item_r.now - ent.t0;
    busy     = item_r.spin ? (sp_lock != 64'd0) : (tk_lock != 64'd0);
    pend_w   = '{lock: item_r.addr, t0: item_r.now, flags: item_r.flags, rng: m_r};

    if (item_r.addr < tbl_rd_r.start) begin
      lo_n = lo_r;
      hx_n = {{(RC-RI){1'b0}}, m_r};
    end else begin
      lo_n = {{(RC-RI){1'b0}}, m_r} + 1'b1;
      hx_n = hx_r;
    end

    if (st_v_r[r_r]) begin
      st_new.total = st_rd_r.total + dur_r;
      st_new.count = st_rd_r.count + 32'd1;
      st_new.tmin  = (st_rd_r.tmin > dur_r) ? dur_r : st_rd_r.tmin;
      st_new.tmax  = (st_rd_r.tmax < dur_r) ? dur_r : st_rd_r.tmax;
      st_new.flags = st_rd_r.flags;
    end else begin
      st_new = '{total: dur_r, count: 32'd1, tmin: dur_r, tmax: dur_r, flags: pf_r};
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    lo_nxt    = lo_r;
    hx_nxt    = hx_r;
    m_nxt     = m_r;
    r_nxt     = r_r;
    dur_nxt   = dur_r;
    pf_nxt    = pf_r;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_ra    = m_r;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_ra     = q_item.idx;
    pd_re     = 1'b0;
    sp_we     = 1'b0;
    tk_we     = 1'b0;
    sp_clr    = 1'b0;
    tk_clr    = 1'b0;
    res_load  = 1'b0;
    res       = '0;
    msum      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          item_nxt = q_item;
          unique case (q_item.op)
            lcrs_pkg::CMD_LOAD: begin
              res_load = 1'b1;
              if (q_item.idx_ok) begin
                tbl_we            = 1'b1;
                res.matched_range = q_item.idx;
              end else begin
                res.status = lcrs_pkg::ST_NO_RANGE;
              end
            end
            lcrs_pkg::CMD_READ: begin
              if (q_item.idx_ok) begin
                st_re     = 1'b1;
                state_nxt = S_READ;
              end else begin
                res_load   = 1'b1;
                res.status = lcrs_pkg::ST_NO_RANGE;
              end
            end
            lcrs_pkg::CMD_BEGIN: begin
              pd_re = 1'b1;
              if (n_eff == '0) begin
                res_load   = 1'b1;
                res.status = lcrs_pkg::ST_NO_RANGE;
              end else begin
                msum      = {1'b0, n_eff} - 1'b1;
                m_nxt     = msum[RI:1];
                tbl_ra    = msum[RI:1];
                tbl_re    = 1'b1;
                lo_nxt    = '0;
                hx_nxt    = n_eff;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              pd_re     = 1'b1;
              state_nxt = S_END;
            end
          endcase
        end
      end
      S_READ: begin
        res_load          = 1'b1;
        state_nxt         = S_IDLE;
        res.matched_range = item_r.idx;
        if (st_v_r[item_r.idx]) begin
          res.dur_sum     = st_rd_r.total;
          res.event_count = st_rd_r.count;
          res.dur_min     = st_rd_r.tmin;
          res.dur_max     = st_rd_r.tmax;
          res.first_flags = st_rd_r.flags;
        end
      end
      S_SRCH: begin
        if (hit) begin
          res_load          = 1'b1;
          state_nxt         = S_IDLE;
          res.matched_range = m_r;
          if (busy) begin
            res.status = lcrs_pkg::ST_BUSY;
          end else begin
            sp_we = item_r.spin;
            tk_we = !item_r.spin;
          end
        end else if (lo_n >= hx_n) begin
          res_load   = 1'b1;
          state_nxt  = S_IDLE;
          res.status = lcrs_pkg::ST_NO_RANGE;
        end else begin
          msum   = {1'b0, lo_n} + {1'b0, hx_n} - 1'b1;
          m_nxt  = msum[RI:1];
          tbl_ra = msum[RI:1];
          tbl_re = 1'b1;
          lo_nxt = lo_n;
          hx_nxt = hx_n;
        end
      end
      S_END: begin
        if (lock_sel == 64'd0 || lock_sel != item_r.addr) begin
          res_load   = 1'b1;
          state_nxt  = S_IDLE;
          res.status = lcrs_pkg::ST_NO_MATCH;
        end else begin
          sp_clr = use_spin;
          tk_clr = !use_spin;
          if (dur_c[63]) begin
            res_load          = 1'b1;
            state_nxt         = S_IDLE;
            res.status        = lcrs_pkg::ST_NEGATIVE;
            res.matched_range = ent.rng;
          end else begin
            st_re     = 1'b1;
            st_ra     = ent.rng;
            r_nxt     = ent.rng;
            dur_nxt   = dur_c;
            pf_nxt    = ent.flags;
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        st_we             = 1'b1;
        res_load          = 1'b1;
        state_nxt         = S_IDLE;
        res.matched_range = r_r;
        res.dur_sum       = st_new.total;
        res.event_count   = st_new.count;
        res.dur_min       = st_new.tmin;
        res.dur_max       = st_new.tmax;
        res.first_flags   = st_new.flags;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    lo_r   <= lo_nxt;
    hx_r   <= hx_nxt;
    m_r    <= m_nxt;
    r_r    <= r_nxt;
    dur_r  <= dur_nxt;
    pf_r   <= pf_nxt;
    if (res_load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
      st_v_r      <= '0;
      sp_v_r      <= '0;
      tk_v_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        rcnt_r <= cfg_wdata;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_we) begin
        st_v_r[r_r] <= 1'b1;
      end
      if (sp_we) begin
        sp_v_r[item_r.cpu] <= 1'b1;
      end else if (sp_clr) begin
        sp_v_r[item_r.cpu] <= 1'b0;
      end
      if (tk_we) begin
        tk_v_r[item_r.task_id] <= 1'b1;
      end else if (tk_clr) begin
        tk_v_r[item_r.task_id] <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/lcrs_checker.sv
// ----------------------------------------------------------------------------
// lcrs_checker
// port-level checks of the lock contention range statistics block
// ----------------------------------------------------------------------------
module lcrs_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input lcrs_pkg::out_t out_data
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= lcrs_pkg::ST_NEGATIVE)
    else $error("unknown status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != lcrs_pkg::ST_DONE |->
      out_data.event_count == 32'd0 && out_data.dur_sum == 64'd0)
    else $error("failed command carries statistics");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind lock_contention_range_stats lcrs_checker u_lcrs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### verif/tb_lock_contention_range_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lock_contention_range_stats
// drives load, begin, end and read beats into the range statistics block
// under several idle patterns, predicts each result from its own copy of the
// table, statistics and pending slots, and checks results in order
// ----------------------------------------------------------------------------
module tb_lock_contention_range_stats;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [8:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  lcrs_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  lcrs_pkg::out_t out_data;

  lock_contention_range_stats u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  logic [8:0] m_count;
  logic [63:0] m_start [lcrs_pkg::RANGE_ENTRIES];
  logic [63:0] m_len [lcrs_pkg::RANGE_ENTRIES];
  lcrs_pkg::stat_t m_stat [lcrs_pkg::RANGE_ENTRIES];
  bit m_svalid [lcrs_pkg::RANGE_ENTRIES];
  lcrs_pkg::pend_t m_spin [lcrs_pkg::CPU_SLOTS];
  lcrs_pkg::pend_t m_task [lcrs_pkg::TASK_SLOTS];

  lcrs_pkg::out_t result_q[$];
  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  longint cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit search_range(input logic [63:0] a, output logic [7:0] hit);
    int lo;
    int hi;
    int m;
    int n;
    lo = 0;
    n = (m_count > lcrs_pkg::RANGE_ENTRIES) ? lcrs_pkg::RANGE_ENTRIES : int'(m_count);
    hi = n - 1;
    hit = '0;
    while (lo <= hi) begin
      m = lo + (hi - lo) / 2;
      if (a >= m_start[m] && a <= m_start[m] + m_len[m]) begin
        hit = m[7:0];
        return 1;
      end
      if (a < m_start[m]) hi = m - 1;
      else lo = m + 1;
    end
    return 0;
  endfunction

  function automatic lcrs_pkg::out_t predict_result(input lcrs_pkg::in_t b);
    lcrs_pkg::out_t r;
    logic [7:0] h;
    logic [63:0] dur;
    lcrs_pkg::pend_t p;
    bit spin;
    bit use_spin;
    int c;
    int t;
    r = '0;
    c = int'(b.cpu_index) % lcrs_pkg::CPU_SLOTS;
    t = int'(b.task_slot) % lcrs_pkg::TASK_SLOTS;
    case (b.command)
      lcrs_pkg::CMD_LOAD, lcrs_pkg::CMD_READ: begin
        r.matched_range = b.range_index;
        if (b.command == lcrs_pkg::CMD_LOAD) begin
          m_start[b.range_index] = b.range_start;
          m_len[b.range_index] = b.range_length;
        end else if (m_svalid[b.range_index]) begin
          r.dur_sum = m_stat[b.range_index].total;
          r.event_count = m_stat[b.range_index].count;
          r.dur_min = m_stat[b.range_index].tmin;
          r.dur_max = m_stat[b.range_index].tmax;
          r.first_flags = m_stat[b.range_index].flags;
        end
        r.status = lcrs_pkg::ST_DONE;
      end
      lcrs_pkg::CMD_BEGIN: begin
        if (!search_range(b.lock_address, h)) begin
          r.status = lcrs_pkg::ST_NO_RANGE;
        end else begin
          r.matched_range = h;
          spin = b.lock_flags == lcrs_pkg::FLAG_SPIN ||
                 b.lock_flags == (lcrs_pkg::FLAG_SPIN | lcrs_pkg::FLAG_READ) ||
                 b.lock_flags == (lcrs_pkg::FLAG_SPIN | lcrs_pkg::FLAG_WRITE);
          p.lock = b.lock_address;
          p.t0 = b.timestamp_ns;
          p.flags = b.lock_flags;
          p.rng = h;
          r.status = lcrs_pkg::ST_DONE;
          if (spin) begin
            if (m_spin[c].lock != 0) r.status = lcrs_pkg::ST_BUSY;
            else m_spin[c] = p;
          end else begin
            if (m_task[t].lock != 0) r.status = lcrs_pkg::ST_BUSY;
            else m_task[t] = p;
          end
        end
      end
      default: begin
        use_spin = m_spin[c].lock != 0;
        p = use_spin ? m_spin[c] : m_task[t];
        if (p.lock == 0 || p.lock != b.lock_address) begin
          r.status = lcrs_pkg::ST_NO_MATCH;
        end else begin
          r.matched_range = p.rng;
          if (use_spin) m_spin[c].lock = '0;
          else m_task[t].lock = '0;
          dur = b.timestamp_ns - p.t0;
          if (dur[63]) begin
            r.status = lcrs_pkg::ST_NEGATIVE;
          end else begin
            if (!m_svalid[p.rng]) begin
              m_svalid[p.rng] = 1;
              m_stat[p.rng] = '{dur, 32'd1, dur, dur, p.flags};
            end else begin
              m_stat[p.rng].total += dur;
              m_stat[p.rng].count += 1;
              if (m_stat[p.rng].tmax < dur) m_stat[p.rng].tmax = dur;
              if (m_stat[p.rng].tmin > dur) m_stat[p.rng].tmin = dur;
            end
            r.dur_sum = m_stat[p.rng].total;
            r.event_count = m_stat[p.rng].count;
            r.dur_min = m_stat[p.rng].tmin;
            r.dur_max = m_stat[p.rng].tmax;
            r.first_flags = m_stat[p.rng].flags;
            r.status = lcrs_pkg::ST_DONE;
          end
        end
      end
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    lcrs_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data);
      end else begin
        e = result_q.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %h got %h", e, out_data);
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays up between back-to-back beats, drops only while idling
  task automatic send_beat(input lcrs_pkg::in_t b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1;
    result_q.push_back(predict_result(b));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_count(input int v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v[8:0];
    m_count = v[8:0];
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic lcrs_pkg::in_t rand_beat();
    lcrs_pkg::in_t b;
    b = '0;
    b.command = 2'($urandom_range(3));
    b.range_index = 8'($urandom);
    b.range_start = {$urandom, $urandom};
    b.range_length = {$urandom, $urandom};
    b.range_kind = 4'($urandom);
    b.lock_address = {$urandom, $urandom};
    b.lock_flags = 6'($urandom);
    b.timestamp_ns = {$urandom, $urandom};
    b.cpu_index = 4'($urandom);
    b.task_slot = 6'($urandom);
    return b;
  endfunction

  // sorted table of n ranges, each spanning a 4k-aligned window
  task automatic load_table(input int n, input logic [63:0] base, input logic [63:0] step);
    lcrs_pkg::in_t b;
    for (int i = 0; i < n; i++) begin
      b = rand_beat();
      b.command = lcrs_pkg::CMD_LOAD;
      b.range_index = 8'(i);
      b.range_start = base + step * 64'(i);
      b.range_length = (i == n - 1 && base != 0) ? 64'hFFFF_FFFF_FFFF_FFFF - b.range_start
                                                  : step / 2;
      send_beat(b);
    end
  endtask

  function automatic logic [63:0] addr_in(input int i, input logic [63:0] base,
                                          input logic [63:0] step);
    return base + step * 64'(i) + 64'($urandom_range(int'(step / 2)));
  endfunction

  task automatic run_items(input int items, input int n, input logic [63:0] base);
    lcrs_pkg::in_t b;
    int k;
    logic [63:0] step;
    step = 64'h1000;
    for (int i = 0; i < items; i++) begin
      b = rand_beat();
      k = int'($urandom_range(n - 1));
      case ($urandom_range(9))
        0: ;
        1, 2: b.command = lcrs_pkg::CMD_READ;
        3, 4, 5: begin
          b.command = lcrs_pkg::CMD_BEGIN;
          b.lock_address = addr_in(k, base, step);
          b.lock_flags = $urandom_range(1) ? 6'($urandom_range(7)) : b.lock_flags;
          b.timestamp_ns = {$urandom_range(3), $urandom};
          b.cpu_index = 4'($urandom_range(3));
          b.task_slot = 6'($urandom_range(7));
        end
        default: begin
          b.command = lcrs_pkg::CMD_END;
          b.cpu_index = 4'($urandom_range(3));
          b.task_slot = 6'($urandom_range(7));
          if (m_spin[b.cpu_index].lock != 0) b.lock_address = m_spin[b.cpu_index].lock;
          else if (m_task[b.task_slot].lock != 0) b.lock_address = m_task[b.task_slot].lock;
          b.timestamp_ns = {$urandom_range(3), $urandom};
        end
      endcase
      if (b.command == lcrs_pkg::CMD_LOAD) begin
        b.range_index = 8'($urandom_range(255, n));
      end
      if (b.command == lcrs_pkg::CMD_READ && $urandom_range(1)) b.range_index = 8'(k);
      send_beat(b);
    end
  endtask

  task automatic test_directed;
    lcrs_pkg::in_t b;
    write_count(0);
    b = rand_beat(); b.command = lcrs_pkg::CMD_BEGIN; b.lock_address = 64'h1000;
    send_beat(b);
    b = rand_beat(); b.command = lcrs_pkg::CMD_END; b.lock_address = '0;
    send_beat(b);
    b = rand_beat(); b.command = lcrs_pkg::CMD_READ; b.range_index = 8'hFF;
    send_beat(b);
    load_table(4, 64'h1000, 64'h1000);
    write_count(4);
    // spin begin, busy, end, negative duration, non-spin, inclusive end
    b = '0; b.command = lcrs_pkg::CMD_BEGIN; b.lock_address = 64'h1800;
    b.lock_flags = lcrs_pkg::FLAG_SPIN;
    b.timestamp_ns = 64'd100; b.cpu_index = 4'hF; b.task_slot = 6'h3F;
    send_beat(b);
    send_beat(b);
    b.command = lcrs_pkg::CMD_END; b.timestamp_ns = 64'd350;
    send_beat(b);
    b.command = lcrs_pkg::CMD_BEGIN; b.lock_address = 64'h2800;
    b.lock_flags = lcrs_pkg::FLAG_SPIN | lcrs_pkg::FLAG_WRITE;
    b.timestamp_ns = 64'd1000;
    send_beat(b);
    b.command = lcrs_pkg::CMD_END; b.lock_address = 64'h2801;
    send_beat(b);
    b.lock_address = 64'h2800; b.timestamp_ns = 64'h8000_0000_0000_1000;
    send_beat(b);
    b.command = lcrs_pkg::CMD_BEGIN; b.lock_address = 64'h4800; b.lock_flags = 6'h3F;
    b.timestamp_ns = 64'hFFFF_FFFF_FFFF_FF00; b.task_slot = '0;
    send_beat(b);
    b.command = lcrs_pkg::CMD_END; b.timestamp_ns = 64'hFFFF_FFFF_FFFF_FFFF;
    send_beat(b);
    b.command = lcrs_pkg::CMD_BEGIN; b.lock_address = 64'h1900;
    b.lock_flags = lcrs_pkg::FLAG_READ;
    send_beat(b);
    b.command = lcrs_pkg::CMD_BEGIN; b.lock_address = 64'h4801;
    send_beat(b);
    b.command = lcrs_pkg::CMD_READ; b.range_index = 8'd3;
    send_beat(b);
    b.range_index = 8'd0;
    send_beat(b);
  endtask

  task automatic test_random(input int items, input int n, input logic [63:0] base);
    drain();
    load_table(n, base, 64'h1000);
    write_count(n);
    run_items(items, n, base);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure;
    drain();
    load_table(8, 64'h10_0000, 64'h1000);
    write_count(8);
    fork
      begin
        hold_off <= 1;
        repeat (300) @(negedge clk);
        hold_off <= 0;
      end
      run_items(40, 8, 64'h10_0000);
    join
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_data = '0;
    hold_off = 0;
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    m_count = 0;
    for (int i = 0; i < lcrs_pkg::RANGE_ENTRIES; i++) begin
      m_stat[i] = '0; m_svalid[i] = 0;
    end
    for (int i = 0; i < lcrs_pkg::CPU_SLOTS; i++) m_spin[i] = '0;
    for (int i = 0; i < lcrs_pkg::TASK_SLOTS; i++) m_task[i] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    test_directed();
    test_random(280, 16, 64'h1_0000);
    send_idle_pct = 63;
    test_random(280, 256, 64'h0);
    send_idle_pct = 0; recv_stall_pct = 63;
    test_random(280, 2, 64'hFFFF_FFFF_FFF0_0000);
    send_idle_pct = 35; recv_stall_pct = 35;
    test_random(280, 64, 64'h20_0000);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_backpressure();
    write_count(511);
    write_count(0);
    drain();
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
